/* rtl/hdtf_pkg.sv */
// Package: shared constants, codes and types of the header/tail frame parser.
`timescale 1ns / 1ps

package hdtf_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAYLOAD_LEN = 4;
    localparam int PAYLOAD_W   = PAYLOAD_LEN * BYTE_W;
    localparam int PCNT_W      = $clog2(PAYLOAD_LEN);
    localparam int SLOT_COUNT  = 10;
    localparam int SLOT_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int NUM_REGS    = 4;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int APB_ADDR_W  = REG_IDX_W + 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'hAF;
    localparam logic [BYTE_W-1:0] FIRST_TAIL_RST    = 8'hFA;
    localparam logic [BYTE_W-1:0] SECOND_TAIL_RST   = 8'hFF;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FIRST_HEADER  = 2'd0,
        REG_SECOND_HEADER = 2'd1,
        REG_FIRST_TAIL    = 2'd2,
        REG_SECOND_TAIL   = 2'd3
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        PH_HEAD1 = 5'b00001,
        PH_HEAD2 = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_TAIL1 = 5'b01000,
        PH_TAIL2 = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] first_header;
        logic [BYTE_W-1:0] second_header;
        logic [BYTE_W-1:0] first_tail;
        logic [BYTE_W-1:0] second_tail;
    } t_cfg;

endpackage

/* rtl/hdtf_if.sv */
// Interfaces: valid/ready channels for received bytes and parse results.
`timescale 1ns / 1ps

interface hdtf_in_if;
    logic                      valid;
    logic                      ready;
    logic [hdtf_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hdtf_out_if;
    logic                           valid;
    logic                           ready;
    logic [hdtf_pkg::STATUS_W-1:0]  status;
    logic [hdtf_pkg::PAYLOAD_W-1:0] payload;
    logic [hdtf_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, output status, output payload, output slot, input ready);
    modport sink   (input valid, input status, input payload, input slot, output ready);
endinterface

/* rtl/header_tail_frame_parser.sv */
// Top level of the header/tail frame parser: register block and parser.
`timescale 1ns / 1ps

// Deframes a byte stream into frames of two header bytes, four payload bytes
// and two tail bytes. Every accepted byte yields exactly one result transfer:
// status busy while a frame is in progress, done with the 32-bit payload and
// its ring slot (0..9, wrapping) when both tail bytes match, or error when a
// tail byte mismatches. A second-header mismatch restarts the search without
// error. The block takes one byte per cycle unless the result sink stalls it;
// each result passes through the input register and then the result register,
// with the phase update between them. The match bytes sit in APB
// registers at 0x0 (first header), 0x4 (second header), 0x8 (first tail) and
// 0xC (second tail); write them only while no transfer is in flight.
module header_tail_frame_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hdtf_in_if.sink                         i_in,
    hdtf_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hdtf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hdtf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hdtf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import hdtf_pkg::*;

    t_cfg w_cfg;

    hdtf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hdtf_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* rtl/hdtf_apb_regs.sv */
// APB register block holding the header and tail match bytes.
`timescale 1ns / 1ps

module hdtf_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hdtf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hdtf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hdtf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output hdtf_pkg::t_cfg                    o_cfg
);
    import hdtf_pkg::*;

    t_cfg          r_cfg;
    t_reg_idx      w_idx;
    logic          w_wr;
    logic [BYTE_W-1:0] w_rd_byte;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_header  <= FIRST_HEADER_RST;
            r_cfg.second_header <= SECOND_HEADER_RST;
            r_cfg.first_tail    <= FIRST_TAIL_RST;
            r_cfg.second_tail   <= SECOND_TAIL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FIRST_HEADER:  r_cfg.first_header  <= pwdata[BYTE_W-1:0];
                REG_SECOND_HEADER: r_cfg.second_header <= pwdata[BYTE_W-1:0];
                REG_FIRST_TAIL:    r_cfg.first_tail    <= pwdata[BYTE_W-1:0];
                REG_SECOND_TAIL:   r_cfg.second_tail   <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FIRST_HEADER:  w_rd_byte = r_cfg.first_header;
            REG_SECOND_HEADER: w_rd_byte = r_cfg.second_header;
            REG_FIRST_TAIL:    w_rd_byte = r_cfg.first_tail;
            REG_SECOND_TAIL:   w_rd_byte = r_cfg.second_tail;
            default:           w_rd_byte = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, w_rd_byte};

endmodule

/* rtl/hdtf_parser.sv */
// Frame parser: input register, one-step phase logic and result register.
`timescale 1ns / 1ps

module hdtf_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hdtf_pkg::t_cfg i_cfg,
    hdtf_in_if.sink        i_in,
    hdtf_out_if.source     o_out
);
    import hdtf_pkg::*;

    // input stage
    logic                 r_s1_valid;
    logic [BYTE_W-1:0]    r_s1_byte;
    // parse state
    t_phase               r_phase,   n_phase;
    logic [PCNT_W-1:0]    r_cnt,     n_cnt;
    logic [PAYLOAD_W-1:0] r_payload, n_payload;
    logic [SLOT_W-1:0]    r_slot,    n_slot;
    // result stage
    logic                 r_out_valid;
    t_status              r_out_status,  n_out_status;
    logic [PAYLOAD_W-1:0] r_out_payload, n_out_payload;
    logic [SLOT_W-1:0]    r_out_slot,    n_out_slot;

    logic w_adv;
    logic w_in_xfer;

    assign w_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_in_xfer = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_out_status;
    assign o_out.payload = r_out_payload;
    assign o_out.slot    = r_out_slot;

    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_payload     = r_payload;
        n_slot        = r_slot;
        n_out_status  = ST_BUSY;
        n_out_payload = '0;
        n_out_slot    = '0;
        unique case (r_phase)
            PH_HEAD1: begin
                if (r_s1_byte == i_cfg.first_header) n_phase = PH_HEAD2;
            end
            PH_HEAD2: begin
                n_cnt   = '0;
                n_phase = (r_s1_byte == i_cfg.second_header) ? PH_DATA : PH_HEAD1;
            end
            PH_DATA: begin
                n_payload[{r_cnt, 3'b000} +: BYTE_W] = r_s1_byte;
                n_cnt = r_cnt + PCNT_W'(1);
                if (r_cnt == PCNT_W'(PAYLOAD_LEN - 1)) n_phase = PH_TAIL1;
            end
            PH_TAIL1: begin
                if (r_s1_byte == i_cfg.first_tail) begin
                    n_phase = PH_TAIL2;
                end else begin
                    n_phase      = PH_HEAD1;
                    n_out_status = ST_ERROR;
                end
            end
            PH_TAIL2: begin
                n_phase = PH_HEAD1;
                if (r_s1_byte == i_cfg.second_tail) begin
                    n_out_status  = ST_DONE;
                    n_out_payload = r_payload;
                    n_out_slot    = r_slot;
                    n_slot = (r_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_slot + SLOT_W'(1);
                end else begin
                    n_out_status = ST_ERROR;
                end
            end
            default: n_phase = PH_HEAD1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_HEAD1;
            r_cnt        <= '0;
            r_slot       <= '0;
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_slot      <= n_slot;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_byte <= i_in.data_byte;
        end
        if (w_adv) begin
            r_payload     <= n_payload;
            r_out_status  <= n_out_status;
            r_out_payload <= n_out_payload;
            r_out_slot    <= n_out_slot;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(SLOT_COUNT))
        else $error("slot counter out of range");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_DONE) |-> (r_out_payload == '0 && r_out_slot == '0))
        else $error("payload or slot nonzero on a result without a frame");

    a_tail2_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_phase == PH_TAIL2) |=> (r_phase == PH_HEAD1))
        else $error("phase did not restart after second tail byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("input stalled while the pipeline had room");

    a_slot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out_status == ST_DONE) |=> (r_slot != $past(r_slot) || SLOT_COUNT == 1))
        else $error("slot counter did not advance after a complete frame");

endmodule

/* tb/sv/hdtf_tb_pkg.sv */
// Scoreboard for the frame parser: byte-level parse prediction and result check.
`timescale 1ns / 1ps

package hdtf_tb_pkg;

    import hdtf_pkg::*;

    typedef struct {
        t_status               status;
        logic [PAYLOAD_W-1:0]  payload;
        logic [SLOT_W-1:0]     slot;
    } t_frame_result;

    class deframe_scoreboard;

        t_cfg                  cfg;
        t_phase                phase;
        int unsigned           byte_count;
        logic [PAYLOAD_W-1:0]  payload_store;
        logic [SLOT_W-1:0]     next_slot;
        t_frame_result         pending_results[$];
        int                    errors;

        function new();
            cfg           = '{FIRST_HEADER_RST, SECOND_HEADER_RST, FIRST_TAIL_RST,
                              SECOND_TAIL_RST};
            phase         = PH_HEAD1;
            byte_count    = 0;
            payload_store = '0;
            next_slot     = '0;
            errors        = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [BYTE_W-1:0] v);
            case (idx)
                REG_FIRST_HEADER:  cfg.first_header  = v;
                REG_SECOND_HEADER: cfg.second_header = v;
                REG_FIRST_TAIL:    cfg.first_tail    = v;
                REG_SECOND_TAIL:   cfg.second_tail   = v;
                default: ;
            endcase
        endfunction

        // Advance the parse state by one accepted byte and queue its result.
        function void note_byte(logic [BYTE_W-1:0] b);
            t_frame_result r;
            r.status  = ST_BUSY;
            r.payload = '0;
            r.slot    = '0;
            case (phase)
                PH_HEAD1: begin
                    if (b == cfg.first_header) phase = PH_HEAD2;
                end
                PH_HEAD2: begin
                    if (b == cfg.second_header) begin
                        byte_count = 0;
                        phase      = PH_DATA;
                    end else begin
                        phase = PH_HEAD1;
                    end
                end
                PH_DATA: begin
                    payload_store[BYTE_W*byte_count +: BYTE_W] = b;
                    byte_count++;
                    if (byte_count >= PAYLOAD_LEN) phase = PH_TAIL1;
                end
                PH_TAIL1: begin
                    if (b == cfg.first_tail) begin
                        phase = PH_TAIL2;
                    end else begin
                        phase    = PH_HEAD1;
                        r.status = ST_ERROR;
                    end
                end
                PH_TAIL2: begin
                    phase = PH_HEAD1;
                    if (b == cfg.second_tail) begin
                        r.status  = ST_DONE;
                        r.payload = payload_store;
                        r.slot    = next_slot;
                        if (next_slot == SLOT_COUNT - 1) next_slot = '0;
                        else next_slot = next_slot + 1'b1;
                    end else begin
                        r.status = ST_ERROR;
                    end
                end
                default: phase = PH_HEAD1;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic [PAYLOAD_W-1:0] payload,
                                   logic [SLOT_W-1:0] slot);
            t_frame_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, status %0d payload %h slot %0d",
                         $time, status, payload, slot);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (status !== e.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, e.status, status);
                errors++;
            end
            if (payload !== e.payload) begin
                $display("%0t: payload mismatch, expected %h, actual %h",
                         $time, e.payload, payload);
                errors++;
            end
            if (slot !== e.slot) begin
                $display("%0t: slot mismatch, expected %0d, actual %0d",
                         $time, e.slot, slot);
                errors++;
            end
        endfunction

    endclass

endpackage

/* tb/sv/tb_header_tail_frame_parser.sv */
// Testbench top: drives byte streams and register settings into the frame parser.
`timescale 1ns / 1ps

module tb_header_tail_frame_parser;

    import hdtf_pkg::*;
    import hdtf_tb_pkg::*;

    localparam int TOTAL_BYTES = 1950;
    localparam int NUM_SEGS    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;

    typedef enum int {
        FR_GOOD,
        FR_BAD_HEAD2,
        FR_BAD_TAIL1,
        FR_BAD_TAIL2,
        FR_NOISE
    } t_frame_kind;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hdtf_in_if  in_ch ();
    hdtf_out_if out_ch ();

    header_tail_frame_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    deframe_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_armed    = 1'b0;

    logic [BYTE_W-1:0] opening_seq [26] = '{
        8'hAA, 8'hAF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'hFA, 8'hFF,
        8'hAA, 8'hAA, 8'hAF,
        8'hAA, 8'hAF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
        8'hAA, 8'hAF, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFA, 8'h00
    };

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result sink: check transfers, random backpressure, one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.status, out_ch.payload, out_ch.slot);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [BYTE_W-1:0] other_than(logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom_range(255));
        if (r == v) r = v + 1'b1;
        return r;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(6, 1)) send_byte(BYTE_W'($urandom_range(255)));
        end else if (kind == FR_BAD_HEAD2) begin
            send_byte(sb.cfg.first_header);
            send_byte(other_than(sb.cfg.second_header));
        end else begin
            send_byte(sb.cfg.first_header);
            send_byte(sb.cfg.second_header);
            repeat (PAYLOAD_LEN) send_byte(BYTE_W'($urandom_range(255)));
            if (kind == FR_BAD_TAIL1) begin
                send_byte(other_than(sb.cfg.first_tail));
            end else begin
                send_byte(sb.cfg.first_tail);
                if (kind == FR_BAD_TAIL2) send_byte(other_than(sb.cfg.second_tail));
                else send_byte(sb.cfg.second_tail);
            end
        end
    endtask

    // Stop offering, wait for every expected transfer, then let the pipe settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write followed by a readback of the same register.
    task automatic program_reg(input t_reg_idx idx, input logic [BYTE_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-BYTE_W){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(APB_DATA_W-BYTE_W){1'b0}}, v}) begin
            $display("%0t: readback mismatch at reg %0d, expected %h, actual %h",
                     $time, idx, v, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] seg_vals [NUM_REGS];
        int                seg_end;
        int                pick;

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 37;
        recv_idle_pct = 78;
        foreach (opening_seq[k]) send_byte(opening_seq[k]);

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            drain();
            case (seg)
                0: seg_vals = '{8'h00, 8'hFF, 8'h00, 8'hFF};
                1: seg_vals = '{8'hFF, 8'h00, 8'hFF, 8'h00};
                3: seg_vals = '{8'h55, 8'h55, 8'h55, 8'h55};
                5: seg_vals = '{FIRST_HEADER_RST, SECOND_HEADER_RST, FIRST_TAIL_RST,
                                SECOND_TAIL_RST};
                default: foreach (seg_vals[r]) seg_vals[r] = BYTE_W'($urandom_range(255));
            endcase
            for (int r = 0; r < NUM_REGS; r++) program_reg(t_reg_idx'(r), seg_vals[r]);
            @(posedge i_clk);

            case (seg % 3)
                0: begin send_idle_pct = 37; recv_idle_pct = 78; end
                1: begin send_idle_pct = 78; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // full-rate sender against a stalled sink fills the pipe
            if (seg == 2) hold_armed = 1'b1;

            seg_end = $size(opening_seq)
                      + (seg + 1) * (TOTAL_BYTES - $size(opening_seq)) / NUM_SEGS;
            while (bytes_sent < seg_end) begin
                pick = $urandom_range(99);
                if (pick < 60) send_frame(FR_GOOD);
                else if (pick < 70) send_frame(FR_BAD_HEAD2);
                else if (pick < 78) send_frame(FR_BAD_TAIL1);
                else if (pick < 86) send_frame(FR_BAD_TAIL2);
                else send_frame(FR_NOISE);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
